// File: hw/rtl/nra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nra_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int SQRT_STEPS = 32;
   localparam int QUOT_BITS = 31;
   localparam int TRIG_STAGES = 10;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [33:0] RCP_6 = 34'(((64'd1 << 36) + 64'd5) / 64'd6);
   localparam logic [33:0] RCP_12 = 34'(((64'd1 << 36) + 64'd11) / 64'd12);
   localparam logic [33:0] RCP_20 = 34'(((64'd1 << 36) + 64'd19) / 64'd20);
   localparam logic [33:0] RCP_30 = 34'(((64'd1 << 36) + 64'd29) / 64'd30);
   localparam logic [33:0] RCP_42 = 34'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [33:0] RCP_56 = 34'(((64'd1 << 36) + 64'd55) / 64'd56);

   typedef struct packed {
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        pitch_angle;
      logic [15:0]        yaw_angle;
      logic signed [31:0] speed;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic               clipped;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0]   pos;
      logic signed [31:0] speed;
      logic [15:0]        pitch;
      logic [15:0]        yaw;
   } carry_type;

   typedef struct packed {
      logic [2:0][31:0] u;
      carry_type        car;
   } unit_type;

   typedef struct packed {
      logic signed [31:0] sin_val;
      logic signed [31:0] cos_val;
   } trig_type;

endpackage

`default_nettype wire

// File: hw/rtl/normalize_rotate_advance.sv
// Moves a point along a rotated unit direction: the direction is normalized, rotated about X
// by the pitch and about Y by the yaw, scaled by the speed and added to the position with
// saturation. The block takes one request per cycle unless rsp_stall holds a result; most
// of its pipeline stages belong to the bit-per-stage square root (32 stages) and the
// bit-per-stage divide (31 stages) that normalize the direction. While rsp_stall holds a
// waiting result, the whole pipeline freezes and req_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module normalize_rotate_advance (
   input var logic              clock,
   input var logic              reset,
   input var logic              req_valid,
   output logic                 req_stall,
   input var nra_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input var logic              rsp_stall,
   output nra_pkg::rsp_type     rsp_data
);

   logic              advance;
   logic              nrm_valid;
   nra_pkg::unit_type nrm_data;
   nra_pkg::trig_type pitch_trig, yaw_trig;
   logic              dly_vld_ff [nra_pkg::TRIG_STAGES];
   nra_pkg::unit_type dly_ff [nra_pkg::TRIG_STAGES];

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   nra_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (nrm_valid),
      .out_data  (nrm_data)
   );

   nra_sincos u_pitch (
      .clock   (clock),
      .advance (advance),
      .angle   (nrm_data.car.pitch),
      .trig    (pitch_trig)
   );

   nra_sincos u_yaw (
      .clock   (clock),
      .advance (advance),
      .angle   (nrm_data.car.yaw),
      .trig    (yaw_trig)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < nra_pkg::TRIG_STAGES; k++) begin
            dly_vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dly_vld_ff[0] <= nrm_valid;
         dly_ff[0] <= nrm_data;
         for (int k = 1; k < nra_pkg::TRIG_STAGES; k++) begin
            dly_vld_ff[k] <= dly_vld_ff[k-1];
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   nra_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dly_vld_ff[nra_pkg::TRIG_STAGES-1]),
      .in_data   (dly_ff[nra_pkg::TRIG_STAGES-1]),
      .pitch     (pitch_trig),
      .yaw       (yaw_trig),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   a_idle_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Request stalled while no result is waiting.");

endmodule

`default_nettype wire

// File: hw/rtl/nra_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module nra_norm (
   input var logic               clock,
   input var logic               reset,
   input var logic               advance,
   input var logic               in_valid,
   input var nra_pkg::req_type   in_data,
   output logic                  out_valid,
   output nra_pkg::unit_type     out_data
);

   typedef struct packed {
      logic                 vld;
      logic                 zero;
      logic [2:0]           neg;
      logic [2:0][31:0]     amp;
      nra_pkg::carry_type   car;
   } side_type;

   typedef struct packed {
      side_type    sd;
      logic [63:0] n;
      logic [63:0] res;
   } root_type;

   typedef struct packed {
      side_type         sd;
      logic [31:0]      mag;
      logic [2:0][30:0] q;
   } quot_type;

   function automatic root_type root_step(root_type s, int j);
      root_type    o;
      logic [63:0] bitv;
      logic [63:0] trial;
      o = s;
      bitv = 64'd1 << (62 - 2 * j);
      trial = s.res + bitv;
      if (s.n >= trial) begin
         o.n = s.n - trial;
         o.res = (s.res >> 1) + bitv;
      end else begin
         o.res = s.res >> 1;
      end
      return o;
   endfunction

   function automatic quot_type quot_step(quot_type s, logic first);
      quot_type    o;
      logic [32:0] t;
      o = s;
      for (int i = 0; i < 3; i++) begin
         t = first ? {1'b0, s.sd.amp[i]} : {s.sd.amp[i], 1'b0};
         if (t >= {1'b0, s.mag}) begin
            o.sd.amp[i] = 32'(t - {1'b0, s.mag});
            o.q[i] = {s.q[i][29:0], 1'b1};
         end else begin
            o.sd.amp[i] = t[31:0];
            o.q[i] = {s.q[i][29:0], 1'b0};
         end
      end
      return o;
   endfunction

   logic [31:0] mv [3];
   side_type    a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff;
   logic [31:0] max_ff, max_in;
   logic [4:0]  sh_ff, sh_in;
   logic [31:0] lz_v;
   logic [4:0]  lz_n;
   logic [63:0] sq_ff [3];
   root_type    rt_ff [nra_pkg::SQRT_STEPS+1];
   root_type    rt_in [nra_pkg::SQRT_STEPS+1];
   quot_type    dv_ff [nra_pkg::QUOT_BITS+1];
   quot_type    dv_in [nra_pkg::QUOT_BITS+1];
   logic        out_vld_ff;
   nra_pkg::unit_type out_ff, out_in;
   logic [31:0] qv [3];

   assign mv[0] = in_data.move_x;
   assign mv[1] = in_data.move_y;
   assign mv[2] = in_data.move_z;

   always_comb begin
      a_in.vld = in_valid;
      a_in.zero = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = mv[i][31];
         a_in.amp[i] = mv[i][31] ? 32'(-mv[i]) : mv[i];
      end
      a_in.car.pos[0] = in_data.pos_x;
      a_in.car.pos[1] = in_data.pos_y;
      a_in.car.pos[2] = in_data.pos_z;
      a_in.car.speed = in_data.speed;
      a_in.car.pitch = in_data.pitch_angle;
      a_in.car.yaw = in_data.yaw_angle;
      max_in = a_in.amp[0];
      if (a_in.amp[1] > max_in) begin
         max_in = a_in.amp[1];
      end
      if (a_in.amp[2] > max_in) begin
         max_in = a_in.amp[2];
      end
   end

   always_comb begin
      lz_v = max_ff;
      lz_n = '0;
      if (lz_v[31:16] == '0) begin
         lz_v = lz_v << 16;
         lz_n = lz_n + 5'd16;
      end
      if (lz_v[31:24] == '0) begin
         lz_v = lz_v << 8;
         lz_n = lz_n + 5'd8;
      end
      if (lz_v[31:28] == '0) begin
         lz_v = lz_v << 4;
         lz_n = lz_n + 5'd4;
      end
      if (lz_v[31:30] == '0) begin
         lz_v = lz_v << 2;
         lz_n = lz_n + 5'd2;
      end
      if (lz_v[31] == 1'b0) begin
         lz_n = lz_n + 5'd1;
      end
      sh_in = (lz_n == '0) ? 5'd0 : lz_n - 5'd1;
      b_in = a_ff;
      b_in.zero = (max_ff == '0);
   end

   always_comb begin
      c_in = b_ff;
      for (int i = 0; i < 3; i++) begin
         c_in.amp[i] = b_ff.amp[i] << sh_ff;
      end
   end

   always_comb begin
      rt_in[0].sd = d_ff;
      rt_in[0].n = sq_ff[0] + sq_ff[1] + sq_ff[2];
      rt_in[0].res = '0;
      for (int j = 0; j < nra_pkg::SQRT_STEPS; j++) begin
         rt_in[j+1] = root_step(rt_ff[j], j);
      end
      dv_in[0].sd = rt_ff[nra_pkg::SQRT_STEPS].sd;
      dv_in[0].mag = rt_ff[nra_pkg::SQRT_STEPS].res[31:0];
      dv_in[0].q = '0;
      for (int k = 0; k < nra_pkg::QUOT_BITS; k++) begin
         dv_in[k+1] = quot_step(dv_ff[k], k == 0);
      end
   end

   always_comb begin
      out_in.car = dv_ff[nra_pkg::QUOT_BITS].sd.car;
      for (int i = 0; i < 3; i++) begin
         qv[i] = {1'b0, dv_ff[nra_pkg::QUOT_BITS].q[i]};
         if (dv_ff[nra_pkg::QUOT_BITS].sd.zero) begin
            out_in.u[i] = '0;
         end else if (dv_ff[nra_pkg::QUOT_BITS].sd.neg[i]) begin
            out_in.u[i] = 32'(-qv[i]);
         end else begin
            out_in.u[i] = qv[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
         b_ff.vld <= 1'b0;
         c_ff.vld <= 1'b0;
         d_ff.vld <= 1'b0;
         for (int j = 0; j <= nra_pkg::SQRT_STEPS; j++) begin
            rt_ff[j].sd.vld <= 1'b0;
         end
         for (int k = 0; k <= nra_pkg::QUOT_BITS; k++) begin
            dv_ff[k].sd.vld <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         a_ff <= a_in;
         max_ff <= max_in;
         b_ff <= b_in;
         sh_ff <= sh_in;
         c_ff <= c_in;
         d_ff <= c_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 64'(c_ff.amp[i]) * 64'(c_ff.amp[i]);
         end
         rt_ff <= rt_in;
         dv_ff <= dv_in;
         out_vld_ff <= dv_ff[nra_pkg::QUOT_BITS].sd.vld;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data = out_ff;

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      rt_ff[nra_pkg::SQRT_STEPS].sd.vld && !rt_ff[nra_pkg::SQRT_STEPS].sd.zero |->
      rt_ff[nra_pkg::SQRT_STEPS].res[63:32] == '0 &&
      rt_ff[nra_pkg::SQRT_STEPS].res[31:30] != 2'b00)
      else $error("Magnitude of a nonzero direction is outside its range.");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff[nra_pkg::QUOT_BITS].sd.vld && !dv_ff[nra_pkg::QUOT_BITS].sd.zero |->
      (!dv_ff[nra_pkg::QUOT_BITS].q[0][30] || dv_ff[nra_pkg::QUOT_BITS].q[0][29:0] == '0) &&
      (!dv_ff[nra_pkg::QUOT_BITS].q[1][30] || dv_ff[nra_pkg::QUOT_BITS].q[1][29:0] == '0) &&
      (!dv_ff[nra_pkg::QUOT_BITS].q[2][30] || dv_ff[nra_pkg::QUOT_BITS].q[2][29:0] == '0))
      else $error("Unit vector component exceeds one.");

endmodule

`default_nettype wire

// File: hw/rtl/nra_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module nra_sincos (
   input var logic          clock,
   input var logic          advance,
   input var logic [15:0]   angle,
   output nra_pkg::trig_type trig
);

   logic [31:0] t;
   logic [29:0] r_ff, r_in;
   logic [1:0]  quad_ff [9];
   logic        fold_ff [9];
   logic [60:0] kp_ff;
   logic [29:0] x_ff [2:7];
   logic [29:0] x2_ff [3:7];
   logic [59:0] xx_ff;
   logic [63:0] ms_ff [3:8];
   logic [63:0] mc_ff [3:8];
   logic [29:0] x2_in;
   logic [30:0] s1, c1, s2, c2, s3, c3;
   logic [30:0] sv, cv, pv, qv;
   logic [31:0] ps, pc;
   nra_pkg::trig_type trig_ff, trig_in;

   always_comb begin
      t = {angle[nra_pkg::ANGLE_BITS-1:0], {(32 - nra_pkg::ANGLE_BITS){1'b0}}};
      r_in = t[29] ? 30'((31'd1 << 30) - {1'b0, t[29:0]}) : t[29:0];
      x2_in = xx_ff[59:30];
      s1 = nra_pkg::ONE_Q30 - 31'(ms_ff[3][63:36]);
      c1 = nra_pkg::ONE_Q30 - 31'(mc_ff[3][63:36]);
      s2 = nra_pkg::ONE_Q30 - 31'(ms_ff[5][63:36]);
      c2 = nra_pkg::ONE_Q30 - 31'(mc_ff[5][63:36]);
      s3 = nra_pkg::ONE_Q30 - 31'(ms_ff[7][63:36]);
      c3 = nra_pkg::ONE_Q30 - 31'(mc_ff[7][63:36]);
      sv = {1'b0, ms_ff[8][59:30]};
      cv = nra_pkg::ONE_Q30 - {2'b00, mc_ff[8][59:31]};
      pv = fold_ff[8] ? cv : sv;
      qv = fold_ff[8] ? sv : cv;
      ps = {1'b0, pv};
      pc = {1'b0, qv};
      case (quad_ff[8])
         2'd0: begin
            trig_in.sin_val = ps;
            trig_in.cos_val = pc;
         end
         2'd1: begin
            trig_in.sin_val = pc;
            trig_in.cos_val = 32'(-ps);
         end
         2'd2: begin
            trig_in.sin_val = 32'(-ps);
            trig_in.cos_val = 32'(-pc);
         end
         default: begin
            trig_in.sin_val = 32'(-pc);
            trig_in.cos_val = ps;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
         quad_ff[0] <= t[31:30];
         fold_ff[0] <= t[29];
         for (int k = 1; k < 9; k++) begin
            quad_ff[k] <= quad_ff[k-1];
            fold_ff[k] <= fold_ff[k-1];
         end
         kp_ff <= 61'(r_ff) * 61'(nra_pkg::HALF_PI_Q30);
         x_ff[2] <= kp_ff[59:30];
         xx_ff <= 60'(kp_ff[59:30]) * 60'(kp_ff[59:30]);
         x_ff[3] <= x_ff[2];
         x2_ff[3] <= x2_in;
         ms_ff[3] <= 64'(x2_in) * 64'(nra_pkg::RCP_42);
         mc_ff[3] <= 64'(x2_in) * 64'(nra_pkg::RCP_56);
         for (int k = 4; k < 8; k++) begin
            x_ff[k] <= x_ff[k-1];
            x2_ff[k] <= x2_ff[k-1];
         end
         ms_ff[4] <= 64'(x2_ff[3]) * 64'(s1);
         mc_ff[4] <= 64'(x2_ff[3]) * 64'(c1);
         ms_ff[5] <= 64'(ms_ff[4][59:30]) * 64'(nra_pkg::RCP_20);
         mc_ff[5] <= 64'(mc_ff[4][59:30]) * 64'(nra_pkg::RCP_30);
         ms_ff[6] <= 64'(x2_ff[5]) * 64'(s2);
         mc_ff[6] <= 64'(x2_ff[5]) * 64'(c2);
         ms_ff[7] <= 64'(ms_ff[6][59:30]) * 64'(nra_pkg::RCP_6);
         mc_ff[7] <= 64'(mc_ff[6][59:30]) * 64'(nra_pkg::RCP_12);
         ms_ff[8] <= 64'(x_ff[7]) * 64'(s3);
         mc_ff[8] <= 64'(x2_ff[7]) * 64'(c3);
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// File: hw/rtl/nra_rotate.sv
`timescale 1ns / 1ps
`default_nettype none

module nra_rotate (
   input var logic               clock,
   input var logic               reset,
   input var logic               advance,
   input var logic               in_valid,
   input var nra_pkg::unit_type  in_data,
   input var nra_pkg::trig_type  pitch,
   input var nra_pkg::trig_type  yaw,
   output logic                  out_valid,
   output nra_pkg::rsp_type      out_data
);

   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   logic vld_ff [5];
   logic out_vld_ff;
   nra_pkg::carry_type car_ff [5];
   nra_pkg::trig_type  yaw0_ff, yaw1_ff;
   logic signed [31:0] ux0_ff, ux1_ff;
   logic signed [63:0] p0_ff [4];
   logic signed [63:0] p0_in [4];
   logic signed [63:0] sm1a, sm1b, sm3a, sm3b;
   logic signed [32:0] ty1_ff, tz1_ff, ty2_ff;
   logic signed [63:0] p2_ff [4];
   logic signed [63:0] p2_in [4];
   logic signed [33:0] w3_ff [3];
   logic signed [33:0] w3_in [3];
   logic signed [65:0] d4_ff [3];
   logic signed [65:0] d4_in [3];
   logic signed [35:0] dd [3];
   logic signed [36:0] tot [3];
   logic signed [31:0] sv [3];
   logic [2:0]         clip;
   nra_pkg::rsp_type   out_ff, out_in;

   always_comb begin
      p0_in[0] = pitch.cos_val * $signed(in_data.u[1]);
      p0_in[1] = pitch.sin_val * $signed(in_data.u[2]);
      p0_in[2] = pitch.cos_val * $signed(in_data.u[2]);
      p0_in[3] = pitch.sin_val * $signed(in_data.u[1]);
      sm1a = p0_ff[0] + p0_ff[1];
      sm1b = p0_ff[2] - p0_ff[3];
      p2_in[0] = yaw1_ff.cos_val * ux1_ff;
      p2_in[1] = yaw1_ff.sin_val * tz1_ff;
      p2_in[2] = yaw1_ff.sin_val * ux1_ff;
      p2_in[3] = yaw1_ff.cos_val * tz1_ff;
      sm3a = p2_ff[0] - p2_ff[1];
      sm3b = p2_ff[2] + p2_ff[3];
      w3_in[0] = 34'(sm3a >>> 30);
      w3_in[1] = 34'(ty2_ff);
      w3_in[2] = 34'(sm3b >>> 30);
      for (int i = 0; i < 3; i++) begin
         d4_in[i] = w3_ff[i] * car_ff[3].speed;
         dd[i] = 36'(d4_ff[i] >>> 30);
         tot[i] = $signed(car_ff[4].pos[i]) + dd[i];
         if (tot[i] > SAT_HI) begin
            sv[i] = 32'sh7FFF_FFFF;
            clip[i] = 1'b1;
         end else if (tot[i] < SAT_LO) begin
            sv[i] = 32'sh8000_0000;
            clip[i] = 1'b1;
         end else begin
            sv[i] = 32'(tot[i]);
            clip[i] = 1'b0;
         end
      end
      out_in.new_x = sv[0];
      out_in.new_y = sv[1];
      out_in.new_z = sv[2];
      out_in.clipped = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         car_ff[0] <= in_data.car;
         for (int k = 1; k < 5; k++) begin
            vld_ff[k] <= vld_ff[k-1];
            car_ff[k] <= car_ff[k-1];
         end
         yaw0_ff <= yaw;
         ux0_ff <= $signed(in_data.u[0]);
         p0_ff <= p0_in;
         yaw1_ff <= yaw0_ff;
         ux1_ff <= ux0_ff;
         ty1_ff <= 33'(sm1a >>> 30);
         tz1_ff <= 33'(sm1b >>> 30);
         p2_ff <= p2_in;
         ty2_ff <= ty1_ff;
         w3_ff <= w3_in;
         d4_ff <= d4_in;
         out_vld_ff <= vld_ff[4];
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data = out_ff;

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.clipped |->
      out_ff.new_x == 32'sh7FFF_FFFF || out_ff.new_x == 32'sh8000_0000 ||
      out_ff.new_y == 32'sh7FFF_FFFF || out_ff.new_y == 32'sh8000_0000 ||
      out_ff.new_z == 32'sh7FFF_FFFF || out_ff.new_z == 32'sh8000_0000)
      else $error("Clipped result has no saturated component.");

endmodule

`default_nettype wire

// File: dv/nra_checker.sv
`timescale 1ns / 1ps

module nra_checker (
   input var logic             clock,
   input var logic             reset,
   input var logic             req_valid,
   input var logic             req_stall,
   input var nra_pkg::req_type req_data,
   input var logic             rsp_valid,
   input var logic             rsp_stall,
   input var nra_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending_count,
   output int                  result_count
);

   nra_pkg::rsp_type expected_positions[$];

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned acc;
      longint unsigned bitv;
      acc = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= acc + bitv) begin
            n = n - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc;
   endfunction

   function automatic void turn_sincos(input logic [15:0] ang, output longint sn,
                                       output longint cs);
      logic [31:0] turn;
      logic [1:0] quad;
      longint unsigned rem, x, x2, s, c, one;
      longint ps, pc;
      logic folded;
      turn = 32'(ang & ((32'd1 << nra_pkg::ANGLE_BITS) - 1)) << (32 - nra_pkg::ANGLE_BITS);
      quad = turn[31:30];
      rem = 64'(turn[29:0]);
      one = 64'(nra_pkg::ONE_Q30);
      folded = 1'b0;
      if (rem >= (64'd1 << 29)) begin
         rem = (64'd1 << 30) - rem;
         folded = 1'b1;
      end
      x = (rem * 64'(nra_pkg::HALF_PI_Q30)) >> 30;
      x2 = (x * x) >> 30;
      s = one - x2 / 42;
      s = one - ((x2 * s) >> 30) / 20;
      s = one - ((x2 * s) >> 30) / 6;
      s = (x * s) >> 30;
      c = one - x2 / 56;
      c = one - ((x2 * c) >> 30) / 30;
      c = one - ((x2 * c) >> 30) / 12;
      c = one - ((x2 * c) >> 30) / 2;
      ps = folded ? longint'(c) : longint'(s);
      pc = folded ? longint'(s) : longint'(c);
      case (quad)
         2'd0: begin sn = ps; cs = pc; end
         2'd1: begin sn = pc; cs = -ps; end
         2'd2: begin sn = -ps; cs = -pc; end
         default: begin sn = -pc; cs = ps; end
      endcase
   endfunction

   function automatic nra_pkg::rsp_type advance_position(input nra_pkg::req_type rq);
      longint dir[3], unitv[3], posv[3];
      longint spd, sn, cs, t0, t1, t2, total;
      longint unsigned mag_in[3], peak, sq_total, mag;
      logic [31:0] res[3];
      logic clip;
      nra_pkg::rsp_type o;
      dir[0] = rq.move_x;
      dir[1] = rq.move_y;
      dir[2] = rq.move_z;
      posv[0] = rq.pos_x;
      posv[1] = rq.pos_y;
      posv[2] = rq.pos_z;
      spd = rq.speed;
      peak = 0;
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         unitv[i] = 0;
         mag_in[i] = dir[i] < 0 ? longint'(-dir[i]) : longint'(dir[i]);
         if (mag_in[i] > peak) peak = mag_in[i];
      end
      if (peak != 0) begin
         while (peak < (64'd1 << 30)) begin
            peak = peak << 1;
            for (int i = 0; i < 3; i++) mag_in[i] = mag_in[i] << 1;
         end
         sq_total = 0;
         for (int i = 0; i < 3; i++) sq_total = sq_total + mag_in[i] * mag_in[i];
         mag = root_floor(sq_total);
         for (int i = 0; i < 3; i++) begin
            t0 = longint'((mag_in[i] << 30) / mag);
            unitv[i] = dir[i] < 0 ? -t0 : t0;
         end
         turn_sincos(rq.pitch_angle, sn, cs);
         t1 = (cs * unitv[1] + sn * unitv[2]) >>> 30;
         t2 = (cs * unitv[2] - sn * unitv[1]) >>> 30;
         unitv[1] = t1;
         unitv[2] = t2;
         turn_sincos(rq.yaw_angle, sn, cs);
         t0 = (cs * unitv[0] - sn * unitv[2]) >>> 30;
         t2 = (sn * unitv[0] + cs * unitv[2]) >>> 30;
         unitv[0] = t0;
         unitv[2] = t2;
      end
      for (int i = 0; i < 3; i++) begin
         total = posv[i] + ((unitv[i] * spd) >>> 30);
         if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
            clip = 1'b1;
         end else if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
            clip = 1'b1;
         end
         res[i] = total[31:0];
      end
      o.new_x = res[0];
      o.new_y = res[1];
      o.new_z = res[2];
      o.clipped = clip;
      return o;
   endfunction

   initial begin
      fail_count = 0;
      result_count = 0;
   end

   assign pending_count = expected_positions.size();

   always @(posedge clock) begin
      nra_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_positions.push_back(advance_position(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_positions.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected result %h", rsp_data);
            end else begin
               want = expected_positions.pop_front();
               if (want.new_x !== rsp_data.new_x || want.new_y !== rsp_data.new_y ||
                   want.new_z !== rsp_data.new_z || want.clipped !== rsp_data.clipped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"Mismatch: expected x=%h y=%h z=%h clip=%b,",
                               " got x=%h y=%h z=%h clip=%b"},
                              want.new_x, want.new_y, want.new_z, want.clipped,
                              rsp_data.new_x, rsp_data.new_y, rsp_data.new_z,
                              rsp_data.clipped);
               end
            end
         end
      end
   end

endmodule

// File: dv/tb_normalize_rotate_advance.sv
`timescale 1ns / 1ps

module tb_normalize_rotate_advance;

   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   nra_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   nra_pkg::rsp_type rsp_data;
   int fail_count, pending_count, result_count;

   int rx_mode = 0;
   bit long_hold_req = 0;
   bit draining = 0;
   int hold = 0;
   int idle_cycles = 0;
   int sent = 0;

   always #2 clock = ~clock;

   normalize_rotate_advance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   nra_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom;
         2: return 32'($signed($urandom) >>> $urandom_range(0, 31));
         3: return 32'($signed($urandom) >>> $urandom_range(10, 24));
         4: return 32'($signed($urandom) >>> 30);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hffff_ffff;
            endcase
         end
      endcase
   endfunction

   function automatic nra_pkg::req_type random_request();
      nra_pkg::req_type rq;
      rq.move_x = rand_word();
      rq.move_y = rand_word();
      rq.move_z = rand_word();
      if ($urandom_range(0, 15) == 0) begin
         rq.move_x = 0;
         rq.move_y = 0;
         rq.move_z = 0;
      end
      rq.pos_x = rand_word();
      rq.pos_y = rand_word();
      rq.pos_z = rand_word();
      rq.pitch_angle = 16'($urandom);
      rq.yaw_angle = 16'($urandom);
      rq.speed = rand_word();
      return rq;
   endfunction

   function automatic nra_pkg::req_type make_request(input logic [31:0] mx, my, mz, px, py, pz,
                                                     input logic [15:0] pitch, yaw,
                                                     input logic [31:0] spd);
      nra_pkg::req_type rq;
      rq.move_x = mx;
      rq.move_y = my;
      rq.move_z = mz;
      rq.pos_x = px;
      rq.pos_y = py;
      rq.pos_z = pz;
      rq.pitch_angle = pitch;
      rq.yaw_angle = yaw;
      rq.speed = spd;
      return rq;
   endfunction

   task automatic send_request(input nra_pkg::req_type rq, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (long_hold_req) begin
         hold = LONG_HOLD;
         long_hold_req = 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold = rx_mode == 1 ? $urandom_range(0, 15) : 0;
      end else if (hold > 0) begin
         hold--;
      end
      @(negedge clock);
      rsp_stall <= hold > 0;
   end

   always @(posedge clock) begin
      if (reset || draining || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout with %0d requests still awaiting results", pending_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      nra_pkg::req_type directed[$];
      int tail;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_request(0, 0, 0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                                      16'h1234, 16'h8000, 32'h7fff_ffff));
      directed.push_back(make_request(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
      directed.push_back(make_request(0, 32'h0001_0000, 0, 0, 0, 0, 16'h4000, 0, 32'h0001_0000));
      directed.push_back(make_request(0, 0, 32'h0001_0000, 0, 0, 0, 16'h8000, 16'h4000,
                                      32'h0001_0000));
      directed.push_back(make_request(0, 0, 32'hffff_0000, 0, 0, 0, 16'hc000, 16'hc000,
                                      32'h0001_0000));
      directed.push_back(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                                      16'h2000, 16'h6000, 32'h7fff_ffff));
      directed.push_back(make_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                      16'hffff, 16'hffff, 32'h7fff_ffff));
      directed.push_back(make_request(32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 16'h1fff, 16'h2001,
                                      32'h8000_0000));
      directed.push_back(make_request(1, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 32'h7fff_ffff));
      directed.push_back(make_request(32'hffff_ffff, 1, 32'hffff_ffff, 0, 0, 0, 16'h0001,
                                      16'h7fff, 32'h8000_0000));
      directed.push_back(make_request(32'h0000_8000, 32'hffff_8000, 32'h0003_0000, 32'h1234_5678,
                                      32'hedcb_a988, 0, 16'h5555, 16'haaaa, 32'hfffe_0000));
      directed.push_back(make_request(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 16'hffff,
                                      16'hffff, 32'h8000_0000));
      directed.push_back(make_request(32'h0001_0000, 32'h0001_0000, 0, 32'h7fff_0000, 0,
                                      32'h8000_ffff, 16'h9000, 16'he000, 32'h0100_0000));
      foreach (directed[i]) send_request(directed[i], $urandom_range(0, 15));

      rx_mode = 0;
      repeat (400) send_request(random_request(), 0);
      rx_mode = 1;
      repeat (500) send_request(random_request(), $urandom_range(0, 15));
      long_hold_req = 1;
      repeat (300) send_request(random_request(), 0);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      repeat (700) send_request(random_request(), $urandom_range(0, 1) ? 0 :
                                $urandom_range(0, 15));
      req_valid <= 1'b0;

      tail = 0;
      while (pending_count != 0 && tail < 4 * IDLE_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      draining = 1;
      repeat (120) @(posedge clock);
      $display("Sent %0d requests (directed extremes, zero vectors, all quadrants, saturation),",
               sent);
      $display("checked %0d results under random gaps, stalls and a long output hold.",
               result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
